FILE: rtl/core/dswrl_pkg.sv
// Shared types and codes of the dual sliding-window rate limiter.
`default_nettype none

package dswrl_pkg;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam logic [1:0] STATUS_GRANTED = 2'd0;
  localparam logic [1:0] STATUS_WAIT    = 2'd1;
  localparam logic [1:0] STATUS_TOO_BIG = 2'd2;

  localparam logic [1:0] REG_REQUEST_LIMIT = 2'd0;
  localparam logic [1:0] REG_TOKEN_LIMIT   = 2'd1;
  localparam logic [1:0] REG_WINDOW_TICKS  = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  typedef struct packed {
    logic        op;
    logic [23:0] tokens;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] wait_ticks;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/dual_sliding_window_rate_limiter.sv
// Top level of the dual sliding-window rate limiter.
`default_nettype none

// Two sliding-window logs (requests, tokens) held in synchronous memories with one read
// and one write port, addressed as rings by head/count registers. Each beat, tick or
// request, passes through accept, one memory read of both log heads, then the check
// step that also decides and charges. Every expiry round adds a pop and a re-read of
// the new head; both logs pop in the same round, so a beat makes as many rounds as the
// larger of its expired request entries and expired token entries. A tick produces
// no result beat; a request produces exactly one. A result waiting on out_stall_i holds
// the check cycle of the next request only. Memories need no clearing after reset.
module dual_sliding_window_rate_limiter
  import dswrl_pkg::*;
#(
  parameter int unsigned LOG_DEPTH = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire in_item_t              in_data_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      out_item_t             out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LOG_DEPTH + 1);
  localparam int unsigned PW = AW + 2;
  localparam logic [PW-1:0] DEPTH_P = PW'(LOG_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(LOG_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(LOG_DEPTH - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_CHK  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic        op_q;
  logic [23:0] cost_q;
  logic [31:0] now_q, now_d;
  logic        pend_q, pend_d;

  logic [15:0] req_lim_q;
  logic [23:0] tok_lim_q;
  logic [19:0] win_q;

  logic [AW-1:0] req_head_q, req_head_d, tok_head_q, tok_head_d;
  logic [CW-1:0] req_cnt_q, req_cnt_d, tok_cnt_q, tok_cnt_d;
  logic [23:0]   tok_sum_q, tok_sum_d;

  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  // stamp memories; token log also keeps the cost beside the stamp
  logic [31:0] req_mem [LOG_DEPTH];
  logic [55:0] tok_mem [LOG_DEPTH];
  logic [31:0] req_rd_q;
  logic [55:0] tok_rd_q;
  logic        req_we, tok_we;
  logic [AW-1:0] req_tail, tok_tail;

  logic        in_acc, out_free;
  logic [31:0] req_age, tok_age;
  logic        req_exp, tok_exp;
  logic [23:0] tok_head_cost;
  logic        over, req_ok, tok_ok;
  logic [19:0] req_wait, tok_wait;
  logic [PW-1:0] req_tail_s, tok_tail_s;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    req_rd_q <= req_mem[req_head_q];
    tok_rd_q <= tok_mem[tok_head_q];
    if (req_we) begin
      req_mem[req_tail] <= now_q;
    end
    if (tok_we) begin
      tok_mem[tok_tail] <= {cost_q, now_q};
    end
  end

  // tail = (head + count) mod depth
  assign req_tail_s = PW'(req_head_q) + PW'(req_cnt_q);
  assign tok_tail_s = PW'(tok_head_q) + PW'(tok_cnt_q);
  assign req_tail   = (req_tail_s >= DEPTH_P) ? AW'(req_tail_s - DEPTH_P) : AW'(req_tail_s);
  assign tok_tail   = (tok_tail_s >= DEPTH_P) ? AW'(tok_tail_s - DEPTH_P) : AW'(tok_tail_s);

  assign tok_head_cost = tok_rd_q[55:32];
  assign req_age = now_q - req_rd_q;
  assign tok_age = now_q - tok_rd_q[31:0];
  assign req_exp = (req_cnt_q != '0) && (req_age >= {12'd0, win_q});
  assign tok_exp = (tok_cnt_q != '0) && (tok_age >= {12'd0, win_q});

  assign req_wait = ((req_cnt_q != '0) && (req_age < {12'd0, win_q})) ?
                    (win_q - req_age[19:0]) : 20'd0;
  assign tok_wait = ((tok_cnt_q != '0) && (tok_age < {12'd0, win_q})) ?
                    (win_q - tok_age[19:0]) : 20'd0;

  assign over   = (cost_q > tok_lim_q) || (!pend_q && (req_lim_q == 16'd0));
  assign req_ok = (req_cnt_q < DEPTH_C) &&
                  ((32'(req_cnt_q) + 32'd1) <= {16'd0, req_lim_q});
  assign tok_ok = (tok_cnt_q < DEPTH_C) &&
                  (({1'b0, tok_sum_q} + {1'b0, cost_q}) <= {1'b0, tok_lim_q});

  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    pend_d      = pend_q;
    req_head_d  = req_head_q;
    tok_head_d  = tok_head_q;
    req_cnt_d   = req_cnt_q;
    tok_cnt_d   = tok_cnt_q;
    tok_sum_d   = tok_sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    req_we      = 1'b0;
    tok_we      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_RD;
          if (in_data_i.op == OP_TICK) begin
            now_d = now_q + 32'd1;
          end
        end
      end
      ST_RD: begin
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (req_exp || tok_exp) begin
          if (req_exp) begin
            req_head_d = (req_head_q == LAST_A) ? '0 : req_head_q + AW'(1);
            req_cnt_d  = req_cnt_q - CW'(1);
          end
          if (tok_exp) begin
            tok_head_d = (tok_head_q == LAST_A) ? '0 : tok_head_q + AW'(1);
            tok_cnt_d  = tok_cnt_q - CW'(1);
            tok_sum_d  = tok_sum_q - ((tok_head_cost <= tok_sum_q) ? tok_head_cost
                                                                    : tok_sum_q);
          end
          state_d = ST_RD;
        end else if (op_q == OP_TICK) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (over) begin
            out_d.status     = STATUS_TOO_BIG;
            out_d.wait_ticks = 20'd0;
          end else if (!pend_q && !req_ok) begin
            out_d.status     = STATUS_WAIT;
            out_d.wait_ticks = req_wait;
          end else begin
            if (!pend_q) begin
              req_we    = 1'b1;
              req_cnt_d = req_cnt_q + CW'(1);
            end
            if (tok_ok) begin
              tok_we           = 1'b1;
              tok_cnt_d        = tok_cnt_q + CW'(1);
              tok_sum_d        = tok_sum_q + cost_q;
              pend_d           = 1'b0;
              out_d.status     = STATUS_GRANTED;
              out_d.wait_ticks = 20'd0;
            end else begin
              pend_d           = 1'b1;
              out_d.status     = STATUS_WAIT;
              out_d.wait_ticks = tok_wait;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      now_q       <= '0;
      pend_q      <= 1'b0;
      req_head_q  <= '0;
      tok_head_q  <= '0;
      req_cnt_q   <= '0;
      tok_cnt_q   <= '0;
      tok_sum_q   <= '0;
      out_valid_q <= 1'b0;
      req_lim_q   <= 16'd60;
      tok_lim_q   <= 24'd150000;
      win_q       <= 20'd60000;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      pend_q      <= pend_d;
      req_head_q  <= req_head_d;
      tok_head_q  <= tok_head_d;
      req_cnt_q   <= req_cnt_d;
      tok_cnt_q   <= tok_cnt_d;
      tok_sum_q   <= tok_sum_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_REQUEST_LIMIT: req_lim_q <= cfg_wdata_i[15:0];
          REG_TOKEN_LIMIT:   tok_lim_q <= cfg_wdata_i;
          REG_WINDOW_TICKS:  win_q     <= cfg_wdata_i[19:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_acc) begin
      op_q   <= in_data_i.op;
      cost_q <= in_data_i.tokens;
    end
  end

  a_req_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_cnt_q <= DEPTH_C)
    else $error("request log count above depth");

  a_tok_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_cnt_q <= DEPTH_C)
    else $error("token log count above depth");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.status == STATUS_GRANTED || out_q.status == STATUS_WAIT ||
                     out_q.status == STATUS_TOO_BIG))
    else $error("undefined status code on result");

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_RD))
    else $error("accepted beat did not start a head read");

  a_grant_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != STATUS_WAIT) |-> (out_q.wait_ticks == 20'd0))
    else $error("nonzero wait on a result that is not a refusal");

endmodule

`default_nettype wire

FILE: verif/dswrl_checker.sv
// Checker for the dual sliding-window rate limiter: admission predictor and result compare.
`timescale 1ns / 1ps

module dswrl_checker
  import dswrl_pkg::*;
#(
  parameter int unsigned LOG_DEPTH = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_stall_i,
  input  wire in_item_t              in_data_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_stall_i,
  input  wire out_item_t             out_data_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                         fail_count_o,
  output int                         awaiting_o
);

  localparam int REQ_LOG = 0;
  localparam int TOK_LOG = 1;

  logic [15:0] limit_requests;
  logic [23:0] limit_tokens;
  logic [19:0] window_len;

  logic [31:0] now_ticks;
  logic [31:0] entry_stamp [2][LOG_DEPTH];
  logic [23:0] entry_cost  [2][LOG_DEPTH];
  int unsigned ring_head [2];
  int unsigned ring_fill [2];
  logic [31:0] window_sum [2];
  logic        tokens_owed;

  out_item_t expected_verdicts [$];

  // Drop entries from the head while their age has reached the window.
  function automatic void expire_log(input int w);
    logic [31:0] age;
    logic [31:0] c;
    bit          done;
    done = 1'b0;
    while (!done && ring_fill[w] != 0) begin
      age = now_ticks - entry_stamp[w][ring_head[w]];
      if (age < {12'd0, window_len}) begin
        done = 1'b1;
      end else begin
        c = {8'd0, entry_cost[w][ring_head[w]]};
        window_sum[w] = window_sum[w] - ((c <= window_sum[w]) ? c : window_sum[w]);
        ring_head[w] = (ring_head[w] + 1) % LOG_DEPTH;
        ring_fill[w] = ring_fill[w] - 1;
      end
    end
  endfunction

  function automatic bit charge_log(input int w, input logic [23:0] cost,
                                    input logic [23:0] limit);
    logic [32:0] total;
    int unsigned slot;
    bit          ok;
    total = {1'b0, window_sum[w]} + {9'd0, cost};
    ok = (ring_fill[w] < LOG_DEPTH) && (total <= {9'd0, limit});
    if (ok) begin
      slot = (ring_head[w] + ring_fill[w]) % LOG_DEPTH;
      entry_stamp[w][slot] = now_ticks;
      entry_cost[w][slot] = cost;
      ring_fill[w] = ring_fill[w] + 1;
      window_sum[w] = window_sum[w] + {8'd0, cost};
    end
    return ok;
  endfunction

  function automatic logic [19:0] ticks_to_free(input int w);
    logic [31:0] age;
    logic [31:0] span;
    span = '0;
    if (ring_fill[w] != 0) begin
      age = now_ticks - entry_stamp[w][ring_head[w]];
      if (age < {12'd0, window_len}) span = {12'd0, window_len} - age;
    end
    return span[19:0];
  endfunction

  function automatic void predict_admission(input logic [23:0] cost, output out_item_t verdict);
    bit req_ok;
    expire_log(REQ_LOG);
    expire_log(TOK_LOG);
    verdict = '0;
    verdict.status = STATUS_GRANTED;
    req_ok = 1'b1;
    if (cost > limit_tokens || (!tokens_owed && limit_requests == 16'd0)) begin
      verdict.status = STATUS_TOO_BIG;
    end else begin
      // a retry after a token refusal skips the request log
      if (!tokens_owed) begin
        req_ok = charge_log(REQ_LOG, 24'd1, {8'd0, limit_requests});
        if (req_ok) begin
          tokens_owed = 1'b1;
        end else begin
          verdict.status = STATUS_WAIT;
          verdict.wait_ticks = ticks_to_free(REQ_LOG);
        end
      end
      if (req_ok) begin
        if (charge_log(TOK_LOG, cost, limit_tokens)) begin
          tokens_owed = 1'b0;
        end else begin
          verdict.status = STATUS_WAIT;
          verdict.wait_ticks = ticks_to_free(TOK_LOG);
        end
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    out_item_t verdict;
    if (!rst_ni) begin
      limit_requests = 16'd60;
      limit_tokens = 24'd150000;
      window_len = 20'd60000;
      now_ticks = '0;
      for (int w = 0; w < 2; w++) begin
        ring_head[w] = 0;
        ring_fill[w] = 0;
        window_sum[w] = '0;
      end
      tokens_owed = 1'b0;
      expected_verdicts.delete();
      fail_count_o = 0;
      awaiting_o = 0;
    end else begin
      // result side first: a beat leaving now belongs to an earlier request
      if (out_valid_i && !out_stall_i) begin
        if (expected_verdicts.size() == 0) begin
          fail_count_o++;
          $display("%0t: result beat with none expected: status %0d wait_ticks %0d",
                   $time, out_data_i.status, out_data_i.wait_ticks);
        end else begin
          verdict = expected_verdicts.pop_front();
          if (out_data_i.status !== verdict.status) begin
            fail_count_o++;
            $display("%0t: status expected %0d got %0d", $time, verdict.status,
                     out_data_i.status);
          end
          if (out_data_i.wait_ticks !== verdict.wait_ticks) begin
            fail_count_o++;
            $display("%0t: wait_ticks expected %0d got %0d", $time, verdict.wait_ticks,
                     out_data_i.wait_ticks);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_REQUEST_LIMIT: limit_requests = cfg_wdata_i[15:0];
          REG_TOKEN_LIMIT:   limit_tokens = cfg_wdata_i[23:0];
          REG_WINDOW_TICKS:  window_len = cfg_wdata_i[19:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.op == OP_REQUEST) begin
          predict_admission(in_data_i.tokens, verdict);
          expected_verdicts.push_back(verdict);
        end else begin
          now_ticks = now_ticks + 32'd1;
          expire_log(REQ_LOG);
          expire_log(TOK_LOG);
        end
      end
      awaiting_o = expected_verdicts.size();
    end
  end

endmodule

FILE: verif/tb.sv
// Testbench top for the dual sliding-window rate limiter: clock, reset, stimulus, verdict.
`timescale 1ns / 1ps

module tb;
  import dswrl_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  // worst beat: accept, head read and check, plus a pop and re-read per expired entry of a full log
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 300;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  int          fail_count;
  int          awaiting;
  int          cycle_count;
  int          tx_idle_pct;
  int          rx_stall_pct;
  int          hold_requests;
  int          holds_served;
  logic [23:0] cur_token_limit;

  dual_sliding_window_rate_limiter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  dswrl_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .awaiting_o   (awaiting)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("dual_sliding_window_rate_limiter regression: fail");
    $finish;
  end

  // Result side: random stall, plus a long hold-off whenever one is requested.
  initial begin
    out_stall_i = 1'b0;
    holds_served = 0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_stall_i <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(input logic op, input logic [23:0] cost);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{op: op, tokens: cost};
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaiting != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_regs(input logic [15:0] req_lim, input logic [23:0] tok_lim,
                            input logic [19:0] win);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_REQUEST_LIMIT;
    cfg_wdata_i <= {8'd0, req_lim};
    @(negedge clk_i);
    cfg_idx_i <= REG_TOKEN_LIMIT;
    cfg_wdata_i <= tok_lim;
    @(negedge clk_i);
    cfg_idx_i <= REG_WINDOW_TICKS;
    cfg_wdata_i <= {4'd0, win};
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_token_limit = tok_lim;
  endtask

  function automatic logic [23:0] pick_cost(input logic [23:0] cap, input int wild_pct);
    logic [23:0] c;
    if ($urandom_range(0, 99) >= wild_pct) begin
      c = 24'($urandom_range(1, cap));
    end else begin
      case ($urandom_range(0, 4))
        0: c = 24'hFFFFFF;
        1: c = 24'($urandom());
        2: c = cur_token_limit;
        3: c = (cur_token_limit == 24'hFFFFFF) ? cur_token_limit : cur_token_limit + 24'd1;
        default: c = 24'd1;
      endcase
    end
    if (c == 24'd0) c = 24'd1;
    return c;
  endfunction

  task automatic run_phase(input logic [15:0] req_lim, input logic [23:0] tok_lim,
                           input logic [19:0] win, input int tx_pct, input int rx_pct,
                           input bit hold, input int n_items, input int tick_pct,
                           input logic [23:0] cap, input int wild_pct);
    settle();
    write_regs(req_lim, tok_lim, win);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    if (hold) hold_requests++;
    repeat (n_items) begin
      if ($urandom_range(0, 99) < tick_pct) send_beat(OP_TICK, 24'($urandom()));
      else send_beat(OP_REQUEST, pick_cost(cap, wild_pct));
    end
  endtask

  initial begin
    logic [23:0] tl;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_REQUEST_LIMIT;
    cfg_wdata_i = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_requests = 0;
    cur_token_limit = 24'd150000;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset limits: grant, token refusal with pending retry, oversize costs
    send_beat(OP_TICK, 24'hFFFFFF);
    send_beat(OP_REQUEST, 24'd1);
    send_beat(OP_REQUEST, 24'd150000);
    send_beat(OP_REQUEST, 24'd149999);
    send_beat(OP_REQUEST, 24'd150001);
    send_beat(OP_REQUEST, 24'hFFFFFF);
    send_beat(OP_TICK, 24'd0);

    // smallest limits and window: request log refusal, expiry after one tick
    settle();
    write_regs(16'd1, 24'd1, 20'd1);
    send_beat(OP_REQUEST, 24'd1);
    send_beat(OP_REQUEST, 24'd1);
    send_beat(OP_TICK, 24'h5A5A5A);
    send_beat(OP_REQUEST, 24'd1);
    send_beat(OP_REQUEST, 24'd2);
    send_beat(OP_TICK, 24'hA5A5A5);
    send_beat(OP_REQUEST, 24'd1);

    // largest limits and window: token budget used up, refusals while pending
    settle();
    write_regs(16'hFFFF, 24'hFFFFFF, 20'hFFFFF);
    send_beat(OP_REQUEST, 24'hFFFFFF);
    send_beat(OP_REQUEST, 24'd1);
    send_beat(OP_TICK, 24'd0);
    send_beat(OP_REQUEST, 24'd1);
    send_beat(OP_REQUEST, 24'hFFFFFF);
    send_beat(OP_TICK, 24'd0);

    run_phase(16'd8, 24'd1000, 20'd20, 0, 0, 1'b0, 90, 40, 24'd300, 10);
    // tiny costs under huge limits so the request log fills to its depth
    run_phase(16'hFFFF, 24'hFFFFFF, 20'hFFFFF, 58, 0, 1'b0, 90, 10, 24'd4, 0);
    run_phase(16'd3, 24'd50000, 20'd5, 0, 58, 1'b0, 90, 45, 24'd30000, 20);
    tl = 24'($urandom_range(1, 24'hFFFFFF));
    run_phase(16'($urandom_range(1, 100)), tl, 20'($urandom_range(1, 40)), 15, 15, 1'b0,
              100, 40, (tl < 24'd3) ? 24'd1 : tl / 24'd3, 15);
    run_phase(16'd40, 24'd5000, 20'd12, 0, 0, 1'b1, 90, 30, 24'd500, 10);
    run_phase(16'd2, 24'd100, 20'd1, 58, 0, 1'b0, 90, 50, 24'd60, 10);

    settle();
    if (fail_count == 0) begin
      $display("dual_sliding_window_rate_limiter regression: pass");
    end else begin
      $display("dual_sliding_window_rate_limiter regression: fail");
    end
    $finish;
  end

endmodule
